// ===== rtl/uled_pkg.sv =====
// ----------------------------------------------------------------------------
// uled_pkg
// Shared constants and types for the line editor with echo.
// ----------------------------------------------------------------------------
package uled_pkg;

    localparam int LINE_SIZE = 64;

    // control characters
    localparam logic [7:0] CH_CTRL_C = 8'h03;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // steps of the erase echo
    localparam logic [1:0] ERASE_BS1   = 2'd0;
    localparam logic [1:0] ERASE_SPACE = 2'd1;
    localparam logic [1:0] ERASE_BS2   = 2'd2;

    typedef struct packed {
        logic [7:0] last_char;
        logic [1:0] erase_phase;
        logic       erase_stop;
    } t_edit_state;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       store_valid;
        logic [5:0] store_index;
        logic [7:0] store_byte;
        logic       line_end;
        logic       line_cancel;
        logic       line_wrap;
    } t_result;

endpackage

// ===== rtl/uled_if.sv =====
// ----------------------------------------------------------------------------
// uled_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface uled_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface uled_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       line_end;
    logic       line_cancel;
    logic       line_wrap;

    modport source (
        output valid, output tx_valid, output tx_byte, output store_valid,
        output store_index, output store_byte, output line_end,
        output line_cancel, output line_wrap, input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input store_valid,
        input store_index, input store_byte, input line_end,
        input line_cancel, input line_wrap, output ready
    );
endinterface

// ===== rtl/uled_step.sv =====
// ----------------------------------------------------------------------------
// uled_step
// Next position, next editor state and result for one item.
// ----------------------------------------------------------------------------
module uled_step #(
    parameter int LINE_SIZE = uled_pkg::LINE_SIZE,
    localparam int PW = $clog2(LINE_SIZE)
) (
    input  logic                  i_action,
    input  logic [7:0]            i_rx_byte,
    input  logic [PW-1:0]         i_pos,
    input  uled_pkg::t_edit_state i_state,
    output logic [PW-1:0]         o_pos,
    output uled_pkg::t_edit_state o_state,
    output uled_pkg::t_result     o_result
);

    localparam logic [PW-1:0] LAST = PW'(LINE_SIZE - 1);
    localparam int PWX = (PW > 6) ? PW : 6;

    logic [PW-1:0]  slot;
    logic [PWX-1:0] slot_x;
    logic [7:0]     lc;

    assign slot_x = PWX'(slot);

    always_comb begin
        o_pos    = i_pos;
        o_state  = i_state;
        o_result = '0;
        slot     = i_pos;
        lc       = i_state.last_char;
        if (!i_action) begin
            o_state.last_char    = i_rx_byte;
            o_result.store_valid = 1'b1;
            o_result.store_byte  = i_rx_byte;
            if (i_pos != LAST) begin
                case (i_rx_byte)
                    uled_pkg::CH_BS: begin
                        o_result.store_byte = '0;
                        if (i_pos != '0) begin
                            o_pos              = i_pos - PW'(1);
                            o_state.erase_stop = 1'b0;
                        end
                    end
                    uled_pkg::CH_CR: begin
                        o_pos             = '0;
                        o_result.line_end = 1'b1;
                    end
                    uled_pkg::CH_CTRL_C: begin
                        slot                 = '0;
                        o_pos                = '0;
                        o_result.line_cancel = 1'b1;
                    end
                    default: begin
                        o_pos = i_pos + PW'(1);
                    end
                endcase
            end else begin
                // full store: last slot takes the byte, position wraps
                o_pos              = '0;
                o_result.line_wrap = 1'b1;
            end
        end else begin
            if (i_state.last_char == uled_pkg::CH_BS && !i_state.erase_stop) begin
                case (i_state.erase_phase)
                    uled_pkg::ERASE_BS1: begin
                        o_result.tx_valid   = 1'b1;
                        o_result.tx_byte    = uled_pkg::CH_BS;
                        o_state.erase_phase = uled_pkg::ERASE_SPACE;
                    end
                    uled_pkg::ERASE_SPACE: begin
                        o_result.tx_valid   = 1'b1;
                        o_result.tx_byte    = uled_pkg::CH_SPACE;
                        o_state.erase_phase = uled_pkg::ERASE_BS2;
                    end
                    uled_pkg::ERASE_BS2: begin
                        o_result.tx_valid   = 1'b1;
                        o_result.tx_byte    = uled_pkg::CH_BS;
                        o_state.erase_phase = uled_pkg::ERASE_BS1;
                        o_state.last_char   = '0;
                        lc                  = '0;
                        if (i_pos == '0) begin
                            o_state.erase_stop = 1'b1;
                        end
                    end
                    default: begin
                        o_result.tx_valid = 1'b0;
                    end
                endcase
            end
            // printable echo
            if (lc >= uled_pkg::CH_SPACE && lc < uled_pkg::CH_DEL) begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = lc;
                o_state.last_char = '0;
            end
        end
        if (o_result.store_valid) begin
            o_result.store_index = slot_x[5:0];
        end
    end

endmodule

// ===== rtl/uart_line_editor_echo_unit.sv =====
// ----------------------------------------------------------------------------
// uart_line_editor_echo_unit
// Line editor for a UART: reports line store writes and produces echo bytes.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  i_in     | in  | action (0 = received byte, 1 = tx ready tick), rx_byte
//  o_out    | out | tx_valid, tx_byte, store_valid/index/byte, line flags
//
//  one item per cycle sustained while o_out is not stalled; an input beat reaches the result beat
//  through the input register and then the result register, with the single editor step between
//  reset clears the position, echo state and both valid flags
//  a stalled result holds in the result register while one more item waits
//  in the input register; input ready drops only when both are occupied
//
module uart_line_editor_echo_unit #(
    parameter int LINE_SIZE = uled_pkg::LINE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uled_in_if.sink     i_in,
    uled_out_if.source  o_out
);

    localparam int PW = $clog2(LINE_SIZE);
    localparam logic [PW-1:0] LAST = PW'(LINE_SIZE - 1);

    // input register
    logic       r_s1_valid;
    logic       r_s1_action;
    logic [7:0] r_s1_rx_byte;

    // editor state
    logic [PW-1:0]         r_pos;
    uled_pkg::t_edit_state r_state;

    // result register
    logic              r_out_valid;
    uled_pkg::t_result r_out;

    logic [PW-1:0]         n_pos;
    uled_pkg::t_edit_state n_state;
    uled_pkg::t_result     n_result;

    logic s1_adv;
    logic in_ready;

    // the input register moves on whenever the result register is free or drains
    assign s1_adv   = !r_out_valid || o_out.ready;
    assign in_ready = !r_s1_valid || s1_adv;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_action  <= i_in.action;
            r_s1_rx_byte <= i_in.rx_byte;
        end
    end

    uled_step #(
        .LINE_SIZE (LINE_SIZE)
    ) u_step (
        .i_action  (r_s1_action),
        .i_rx_byte (r_s1_rx_byte),
        .i_pos     (r_pos),
        .i_state   (r_state),
        .o_pos     (n_pos),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // state commits as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_state <= '0;
        end else if (s1_adv && r_s1_valid) begin
            r_pos   <= n_pos;
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tx_valid    = r_out.tx_valid;
    assign o_out.tx_byte     = r_out.tx_byte;
    assign o_out.store_valid = r_out.store_valid;
    assign o_out.store_index = r_out.store_index;
    assign o_out.store_byte  = r_out.store_byte;
    assign o_out.line_end    = r_out.line_end;
    assign o_out.line_cancel = r_out.line_cancel;
    assign o_out.line_wrap   = r_out.line_wrap;

    // position stays inside the line store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST)
        else $error("write position beyond last slot");

    // erase echo only has three steps
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.erase_phase != 2'd3)
        else $error("erase phase out of range");

    // a received byte always yields a store write result
    a_byte_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_valid && !r_s1_action) |=> (r_out_valid && r_out.store_valid))
        else $error("received byte without store write");

    // a result never carries both an echo and a store write
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.tx_valid && r_out.store_valid))
        else $error("echo and store write in one result");

endmodule
